>>> rtl/core/round_robin_task_scheduler_defines.svh
// Assertion macros used by the scheduler checker
`ifndef ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RRTS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RRTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/rrts_pkg.sv
// Types and constants of the round-robin task scheduler
package rrts_pkg;

    localparam int TASK_W = 6;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_SLEEP = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_WRONG = 2'd2
    } sts_code_t;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_ALLOC = 2'd1,
        SLOT_RUN   = 2'd2
    } slot_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_RUN_CHK,
        S_TICK,
        S_TICK_OUT,
        S_SLEEP_CHK,
        S_SLEEP_FIND,
        S_SLEEP_SHIFT,
        S_SLEEP_OUT
    } state_t;

    typedef enum logic [1:0] {
        SCAN_NONE,
        SCAN_ALLOC,
        SCAN_FIND,
        SCAN_SHIFT
    } scan_mode_t;

    typedef enum logic [1:0] {
        SWR_NONE,
        SWR_CHK_ALLOC,
        SWR_ID_RUN,
        SWR_ID_ALLOC
    } slot_wr_t;

    typedef enum logic [1:0] {
        LRD_SCAN,
        LRD_CUR,
        LRD_TICK
    } list_rd_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_ALLOC,
        EMIT_FULL,
        EMIT_OK,
        EMIT_WRONG,
        EMIT_SWITCH
    } emit_t;

    typedef struct packed {
        logic       capture;
        logic       clear_step;
        scan_mode_t scan_init;
        logic       scan_step;
        logic       slot_rd_id;
        slot_wr_t   slot_wr;
        logic       list_append;
        logic       shift_wr;
        logic       tick_adv;
        logic       sleep_found;
        list_rd_t   list_rd;
        emit_t      emit;
    } ctl_t;

    typedef struct packed {
        logic clear_last;
        logic id_ok;
        logic slot_is_alloc;
        logic slot_is_run;
        logic hit_free;
        logic hit_id;
        logic scan_done;
        logic has_room;
        logic multi;
        logic switch_ok;
    } dp_status_t;

endpackage

>>> rtl/core/rrts_ctrl.sv
// Sequencing state machine of the round-robin task scheduler
module rrts_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  rrts_pkg::req_t     req_type,
    input  rrts_pkg::dp_status_t sts,
    output logic               busy,
    output rrts_pkg::ctl_t     ctl
);

    rrts_pkg::state_t state_reg;
    rrts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rrts_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rrts_pkg::S_CLEAR:
            begin
                if (sts.clear_last)
                begin
                    state_next = rrts_pkg::S_IDLE;
                end
            end
            rrts_pkg::S_IDLE:
            begin
                if (start)
                begin
                    case (req_type)
                        rrts_pkg::REQ_ALLOC: state_next = rrts_pkg::S_ALLOC;
                        rrts_pkg::REQ_RUN:   state_next = rrts_pkg::S_RUN_CHK;
                        rrts_pkg::REQ_TICK:  state_next = rrts_pkg::S_TICK;
                        default:             state_next = rrts_pkg::S_SLEEP_CHK;
                    endcase
                end
            end
            rrts_pkg::S_ALLOC:
            begin
                if (sts.hit_free || sts.scan_done)
                begin
                    state_next = rrts_pkg::S_IDLE;
                end
            end
            rrts_pkg::S_RUN_CHK:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
            rrts_pkg::S_TICK:
            begin
                state_next = sts.multi ? rrts_pkg::S_TICK_OUT : rrts_pkg::S_IDLE;
            end
            rrts_pkg::S_TICK_OUT:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
            rrts_pkg::S_SLEEP_CHK:
            begin
                if (sts.id_ok && sts.slot_is_run)
                begin
                    state_next = rrts_pkg::S_SLEEP_FIND;
                end
                else
                begin
                    state_next = rrts_pkg::S_IDLE;
                end
            end
            rrts_pkg::S_SLEEP_FIND:
            begin
                if (sts.hit_id)
                begin
                    state_next = rrts_pkg::S_SLEEP_SHIFT;
                end
                else if (sts.scan_done)
                begin
                    state_next = rrts_pkg::S_IDLE;
                end
            end
            rrts_pkg::S_SLEEP_SHIFT:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.switch_ok ? rrts_pkg::S_SLEEP_OUT : rrts_pkg::S_IDLE;
                end
            end
            rrts_pkg::S_SLEEP_OUT:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
            default:
            begin
                state_next = rrts_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl             = '0;
        ctl.scan_init   = rrts_pkg::SCAN_NONE;
        ctl.slot_wr     = rrts_pkg::SWR_NONE;
        ctl.list_rd     = rrts_pkg::LRD_SCAN;
        ctl.emit        = rrts_pkg::EMIT_NONE;
        case (state_reg)
            rrts_pkg::S_CLEAR:
            begin
                ctl.clear_step = 1'b1;
            end
            rrts_pkg::S_IDLE:
            begin
                // look up the named slot while the transaction is taken
                ctl.slot_rd_id = 1'b1;
                if (start)
                begin
                    ctl.capture = 1'b1;
                    if (req_type == rrts_pkg::REQ_ALLOC)
                    begin
                        ctl.scan_init = rrts_pkg::SCAN_ALLOC;
                    end
                end
            end
            rrts_pkg::S_ALLOC:
            begin
                ctl.scan_step = 1'b1;
                if (sts.hit_free)
                begin
                    ctl.slot_wr = rrts_pkg::SWR_CHK_ALLOC;
                    ctl.emit    = rrts_pkg::EMIT_ALLOC;
                end
                else if (sts.scan_done)
                begin
                    ctl.emit = rrts_pkg::EMIT_FULL;
                end
            end
            rrts_pkg::S_RUN_CHK:
            begin
                if (sts.id_ok && sts.slot_is_alloc && sts.has_room)
                begin
                    ctl.slot_wr     = rrts_pkg::SWR_ID_RUN;
                    ctl.list_append = 1'b1;
                    ctl.emit        = rrts_pkg::EMIT_OK;
                end
                else
                begin
                    ctl.emit = rrts_pkg::EMIT_WRONG;
                end
            end
            rrts_pkg::S_TICK:
            begin
                if (sts.multi)
                begin
                    ctl.tick_adv = 1'b1;
                    ctl.list_rd  = rrts_pkg::LRD_TICK;
                end
                else
                begin
                    ctl.emit = rrts_pkg::EMIT_OK;
                end
            end
            rrts_pkg::S_TICK_OUT:
            begin
                ctl.emit = rrts_pkg::EMIT_SWITCH;
            end
            rrts_pkg::S_SLEEP_CHK:
            begin
                if (sts.id_ok && sts.slot_is_run)
                begin
                    ctl.slot_wr   = rrts_pkg::SWR_ID_ALLOC;
                    ctl.scan_init = rrts_pkg::SCAN_FIND;
                end
                else
                begin
                    ctl.emit = rrts_pkg::EMIT_WRONG;
                end
            end
            rrts_pkg::S_SLEEP_FIND:
            begin
                ctl.scan_step = 1'b1;
                if (sts.hit_id)
                begin
                    ctl.sleep_found = 1'b1;
                    ctl.scan_init   = rrts_pkg::SCAN_SHIFT;
                end
                else if (sts.scan_done)
                begin
                    ctl.emit = rrts_pkg::EMIT_OK;
                end
            end
            rrts_pkg::S_SLEEP_SHIFT:
            begin
                ctl.scan_step = 1'b1;
                ctl.shift_wr  = 1'b1;
                if (sts.scan_done)
                begin
                    if (sts.switch_ok)
                    begin
                        ctl.list_rd = rrts_pkg::LRD_CUR;
                    end
                    else
                    begin
                        ctl.emit = rrts_pkg::EMIT_OK;
                    end
                end
            end
            rrts_pkg::S_SLEEP_OUT:
            begin
                ctl.emit = rrts_pkg::EMIT_SWITCH;
            end
            default:
            begin
                ctl.emit = rrts_pkg::EMIT_NONE;
            end
        endcase
    end

    assign busy = (state_reg != rrts_pkg::S_IDLE);

endmodule

>>> rtl/core/rrts_datapath.sv
// Slot table, run list, scan counter and result registers of the scheduler
module rrts_datapath #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [rrts_pkg::TASK_W-1:0] task_id,
    input  rrts_pkg::ctl_t              ctl,
    output rrts_pkg::dp_status_t        sts,
    output logic                        done,
    output logic [rrts_pkg::TASK_W-1:0] result_task,
    output logic                        do_switch,
    output logic [1:0]                  status
);

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam int CNT_W  = $clog2(TASK_SLOTS + 1);
    localparam int TW     = rrts_pkg::TASK_W;

    rrts_pkg::slot_t  slot_mem [TASK_SLOTS];
    logic [TW-1:0]    list_mem [TASK_SLOTS];
    rrts_pkg::slot_t  slot_q;
    logic [TW-1:0]    list_q;

    logic [TW-1:0]    id_reg;
    logic [CNT_W-1:0] scan_reg, scan_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [CNT_W-1:0] chk_reg, chk_next;
    logic             chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0] run_count_reg, run_count_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic             was_cur_reg;
    logic [SLOT_W-1:0] clr_reg;

    logic                  done_reg;
    logic [TW-1:0]         result_task_reg, result_task_next;
    logic                  do_switch_reg, do_switch_next;
    rrts_pkg::sts_code_t   status_reg, status_next;

    logic              scan_lt;
    logic [CNT_W-1:0]  cur_ext, cur_inc, cur_adj, count_dec;
    logic [SLOT_W-1:0] tick_cur, cur_wrap;
    logic [SLOT_W-1:0] slot_raddr, slot_waddr, list_raddr, list_waddr;
    rrts_pkg::slot_t   slot_wdata;
    logic [TW-1:0]     list_wdata;
    logic              slot_we, list_we;

    assign scan_lt   = (scan_reg < lim_reg);
    assign cur_ext   = CNT_W'(cur_reg);
    assign cur_inc   = cur_ext + CNT_W'(1);
    assign tick_cur  = (cur_inc >= run_count_reg) ? '0 : SLOT_W'(cur_inc);
    assign count_dec = run_count_reg - CNT_W'(1);
    // entries ahead of the current one slide down by one
    assign cur_adj   = (chk_reg < cur_ext) ? (cur_ext - CNT_W'(1)) : cur_ext;
    assign cur_wrap  = (cur_adj >= count_dec) ? '0 : SLOT_W'(cur_adj);

    // scan counter: read address leads, chk_reg names the data in the next cycle
    always_comb
    begin
        scan_next      = scan_reg;
        lim_next       = lim_reg;
        chk_next       = chk_reg;
        chk_valid_next = chk_valid_reg;
        case (ctl.scan_init)
            rrts_pkg::SCAN_ALLOC:
            begin
                scan_next      = '0;
                lim_next       = CNT_W'(TASK_SLOTS);
                chk_valid_next = 1'b0;
            end
            rrts_pkg::SCAN_FIND:
            begin
                scan_next      = '0;
                lim_next       = run_count_reg;
                chk_valid_next = 1'b0;
            end
            rrts_pkg::SCAN_SHIFT:
            begin
                scan_next      = chk_reg + CNT_W'(1);
                lim_next       = run_count_reg;
                chk_valid_next = 1'b0;
            end
            default:
            begin
                if (ctl.scan_step)
                begin
                    chk_valid_next = scan_lt;
                    chk_next       = scan_reg;
                    if (scan_lt)
                    begin
                        scan_next = scan_reg + CNT_W'(1);
                    end
                end
            end
        endcase
    end

    always_comb
    begin
        run_count_next = run_count_reg;
        cur_next       = cur_reg;
        if (ctl.list_append)
        begin
            run_count_next = run_count_reg + CNT_W'(1);
        end
        else if (ctl.sleep_found)
        begin
            run_count_next = count_dec;
        end
        if (ctl.tick_adv)
        begin
            cur_next = tick_cur;
        end
        else if (ctl.sleep_found)
        begin
            cur_next = cur_wrap;
        end
    end

    always_comb
    begin
        slot_raddr = ctl.slot_rd_id ? SLOT_W'(task_id) : SLOT_W'(scan_reg);
        case (ctl.list_rd)
            rrts_pkg::LRD_CUR:  list_raddr = cur_reg;
            rrts_pkg::LRD_TICK: list_raddr = tick_cur;
            default:            list_raddr = SLOT_W'(scan_reg);
        endcase
    end

    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = SLOT_W'(id_reg);
        slot_wdata = rrts_pkg::SLOT_FREE;
        if (ctl.clear_step)
        begin
            slot_we    = 1'b1;
            slot_waddr = clr_reg;
            slot_wdata = (clr_reg == '0) ? rrts_pkg::SLOT_RUN : rrts_pkg::SLOT_FREE;
        end
        else
        begin
            case (ctl.slot_wr)
                rrts_pkg::SWR_CHK_ALLOC:
                begin
                    slot_we    = 1'b1;
                    slot_waddr = SLOT_W'(chk_reg);
                    slot_wdata = rrts_pkg::SLOT_ALLOC;
                end
                rrts_pkg::SWR_ID_RUN:
                begin
                    slot_we    = 1'b1;
                    slot_wdata = rrts_pkg::SLOT_RUN;
                end
                rrts_pkg::SWR_ID_ALLOC:
                begin
                    slot_we    = 1'b1;
                    slot_wdata = rrts_pkg::SLOT_ALLOC;
                end
                default:
                begin
                    slot_we = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        list_we    = 1'b0;
        list_waddr = SLOT_W'(run_count_reg);
        list_wdata = id_reg;
        if (ctl.clear_step)
        begin
            list_we    = 1'b1;
            list_waddr = clr_reg;
            list_wdata = '0;
        end
        else if (ctl.list_append)
        begin
            list_we = 1'b1;
        end
        else if (ctl.shift_wr && chk_valid_reg)
        begin
            list_we    = 1'b1;
            list_waddr = SLOT_W'(chk_reg - CNT_W'(1));
            list_wdata = list_q;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_q <= slot_mem[slot_raddr];
        list_q <= list_mem[list_raddr];
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        if (list_we)
        begin
            list_mem[list_waddr] <= list_wdata;
        end
    end

    always_comb
    begin
        result_task_next = '0;
        do_switch_next   = 1'b0;
        status_next      = rrts_pkg::STS_OK;
        case (ctl.emit)
            rrts_pkg::EMIT_ALLOC:  result_task_next = TW'(chk_reg);
            rrts_pkg::EMIT_FULL:   status_next      = rrts_pkg::STS_FULL;
            rrts_pkg::EMIT_WRONG:  status_next      = rrts_pkg::STS_WRONG;
            rrts_pkg::EMIT_SWITCH:
            begin
                result_task_next = list_q;
                do_switch_next   = 1'b1;
            end
            default:
            begin
                status_next = rrts_pkg::STS_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chk_valid_reg <= 1'b0;
            run_count_reg <= CNT_W'(1);
            cur_reg       <= '0;
            clr_reg       <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            chk_valid_reg <= chk_valid_next;
            run_count_reg <= run_count_next;
            cur_reg       <= cur_next;
            done_reg      <= (ctl.emit != rrts_pkg::EMIT_NONE);
            if (ctl.clear_step)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg <= scan_next;
        lim_reg  <= lim_next;
        chk_reg  <= chk_next;
        if (ctl.capture)
        begin
            id_reg <= task_id;
        end
        if (ctl.sleep_found)
        begin
            was_cur_reg <= (chk_reg == cur_ext);
        end
        if (ctl.emit != rrts_pkg::EMIT_NONE)
        begin
            result_task_reg <= result_task_next;
            do_switch_reg   <= do_switch_next;
            status_reg      <= status_next;
        end
    end

    assign sts.clear_last    = (clr_reg == SLOT_W'(TASK_SLOTS - 1));
    assign sts.id_ok         = (int'(id_reg) < TASK_SLOTS);
    assign sts.slot_is_alloc = (slot_q == rrts_pkg::SLOT_ALLOC);
    assign sts.slot_is_run   = (slot_q == rrts_pkg::SLOT_RUN);
    assign sts.hit_free      = chk_valid_reg && (slot_q == rrts_pkg::SLOT_FREE);
    assign sts.hit_id        = chk_valid_reg && (list_q == id_reg);
    assign sts.scan_done     = !chk_valid_reg && !scan_lt;
    assign sts.has_room      = (run_count_reg < CNT_W'(TASK_SLOTS));
    assign sts.multi         = (run_count_reg >= CNT_W'(2));
    assign sts.switch_ok     = was_cur_reg && (run_count_reg != '0);

    assign done        = done_reg;
    assign result_task = result_task_reg;
    assign do_switch   = do_switch_reg;
    assign status      = status_reg;

endmodule

>>> rtl/core/round_robin_task_scheduler.sv
// Top level of the round-robin task scheduler
//
// Requests enter on start/req_type/task_id; a transaction is taken at a
// rising edge with start high and busy low. Every request yields exactly one
// result, shown on result_task/do_switch/status for a single cycle with done
// high; the receiver cannot stall it, so it must sample on done.
// Steps from the accepting edge to the done cycle:
//   run and tick need no scan,
//   allocate scans the slot table one entry a cycle from slot 0 through
//   the single read port,
//   sleep searches the run list, then compacts it one entry a cycle
//   through the single read and write port of the list.
// One request is in flight at a time; busy stays high until its result is
// registered, and a new request can be taken in the cycle done is shown.
// After reset the block sweeps every entry of both tables with busy high,
// leaving task 0 running alone as the current task.
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  req_type,
    input  logic [rrts_pkg::TASK_W-1:0] task_id,
    output logic                        done,
    output logic [rrts_pkg::TASK_W-1:0] result_task,
    output logic                        do_switch,
    output logic [1:0]                  status
);

    rrts_pkg::ctl_t       ctl;
    rrts_pkg::dp_status_t sts;

    rrts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .req_type (rrts_pkg::req_t'(req_type)),
        .sts      (sts),
        .busy     (busy),
        .ctl      (ctl)
    );

    rrts_datapath #(
        .TASK_SLOTS (TASK_SLOTS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .task_id     (task_id),
        .ctl         (ctl),
        .sts         (sts),
        .done        (done),
        .result_task (result_task),
        .do_switch   (do_switch),
        .status      (status)
    );

endmodule

>>> rtl/core/rrts_checker.sv
// Port-level checker of the round-robin task scheduler and its bind
`include "round_robin_task_scheduler_defines.svh"

module rrts_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [rrts_pkg::TASK_W-1:0] result_task,
    input logic                        do_switch,
    input logic [1:0]                  status
);

    `RRTS_ASSERT_NOW(a_done_idle, done, !busy, "result shown while a transaction is in flight")

    `RRTS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction left busy low")

    `RRTS_ASSERT_NEXT(a_done_single, done, !done, "one transaction gave two results")

    `RRTS_ASSERT_NOW(a_switch_ok, done && do_switch, status == rrts_pkg::STS_OK, "switch reported with an error")

    `RRTS_ASSERT_NOW(a_error_clean, done && (status != rrts_pkg::STS_OK), (result_task == '0) && !do_switch, "error result carries a task or a switch")

endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (.*);
